// ===== hw/rtl/kfi_pkg.sv =====
package kfi_pkg;

  localparam int TABLE_ADDR_BITS_DEF = 8;
  localparam int VAL_W     = 32;
  localparam int TIME_W    = 32;
  localparam int PHASE_W   = 17;
  localparam int MU_W      = 17;
  // quotient of (|dt| << 16) / span
  localparam int QUO_W     = TIME_W + 16;
  // blend path: operand, operand, product, sum
  localparam int BLEND_LAT = 4;

  localparam logic [PHASE_W-1:0] PHASE_ONE = 17'h10000;
  localparam logic [VAL_W-1:0]   VAL_MAX   = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0]   VAL_MIN   = 32'h8000_0000;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned LOG10_2_Q30 = 64'd323228497;

  typedef enum logic [3:0] {
    MODE_LINEAR    = 4'd0,
    MODE_COSINE    = 4'd1,
    MODE_FALL      = 4'd2,
    MODE_RISE      = 4'd3,
    MODE_LOG_FALL  = 4'd4,
    MODE_HOLD      = 4'd5,
    MODE_FORWARD   = 4'd6,
    MODE_BACKWARD  = 4'd7,
    MODE_GAMMA     = 4'd8,
    MODE_INV_GAMMA = 4'd9
  } mode_t;

  typedef enum logic [1:0] {
    TBL_COS  = 2'd0,
    TBL_LOG  = 2'd1,
    TBL_GAM  = 2'd2,
    TBL_IGAM = 2'd3
  } tbl_t;

  function automatic tbl_t tbl_of(logic [3:0] mode);
    tbl_t res;
    unique case (mode_t'(mode))
      MODE_LOG_FALL:  res = TBL_LOG;
      MODE_GAMMA:     res = TBL_GAM;
      MODE_INV_GAMMA: res = TBL_IGAM;
      default:        res = TBL_COS;
    endcase
    return res;
  endfunction

  // table generation, evaluated at elaboration only
  function automatic longint unsigned mul30(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned pow30(longint unsigned y, int k);
    longint unsigned r;
    r = Q30_ONE;
    for (int i = 0; i < k; i++) r = mul30(r, y);
    return r;
  endfunction

  function automatic longint unsigned root30(longint unsigned t, int k);
    longint unsigned y, c;
    y = 64'd0;
    for (int b = 30; b >= 0; b--) begin
      c = y | (64'd1 << b);
      if (c <= Q30_ONE && pow30(c, k) <= t) y = c;
    end
    return y;
  endfunction

  function automatic longint unsigned cos_mu30(longint unsigned x);
    longint unsigned xr, a, a2, term, p, s;
    longint sum;
    xr   = (x <= (Q30_ONE >> 1)) ? x : Q30_ONE - x;
    a    = mul30(xr, PI_Q30);
    a2   = mul30(a, a);
    term = Q30_ONE;
    sum  = Q30_ONE;
    for (int k = 1; k <= 10; k++) begin
      p = mul30(term, a2);
      // divide by (2k-1)(2k)
      unique case (k)
        1:       term = p / 2;
        2:       term = p / 12;
        3:       term = p / 30;
        4:       term = p / 56;
        5:       term = p / 90;
        6:       term = p / 132;
        7:       term = p / 182;
        8:       term = p / 240;
        9:       term = p / 306;
        default: term = p / 380;
      endcase
      if ((k & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    if (sum > Q30_ONE) sum = Q30_ONE;
    s = sum;
    return (x <= (Q30_ONE >> 1)) ? ((Q30_ONE - s) >> 1) : ((Q30_ONE + s) >> 1);
  endfunction

  function automatic longint unsigned log_fall30(longint unsigned x);
    longint unsigned z, ip, fr, r;
    z  = Q30_ONE + 64'd9 * (Q30_ONE - x);
    ip = 64'd0;
    fr = 64'd0;
    for (int j = 0; j < 4; j++) begin
      if (z >= (Q30_ONE << 1)) begin
        z  = z >> 1;
        ip = ip + 64'd1;
      end
    end
    for (int b = 29; b >= 0; b--) begin
      z = mul30(z, z);
      if (z >= (Q30_ONE << 1)) begin
        z  = z >> 1;
        fr = fr | (64'd1 << b);
      end
    end
    r = mul30((ip << 30) + fr, LOG10_2_Q30);
    return (r > Q30_ONE) ? Q30_ONE : r;
  endfunction

  function automatic logic [MU_W-1:0] to_q16(longint unsigned v);
    return MU_W'((v + 64'd8192) >> 14);
  endfunction

  function automatic logic [MU_W-1:0] rom_entry(tbl_t sel, int i, int n);
    longint unsigned x;
    logic [MU_W-1:0] res;
    x = 64'(i);
    x = x << (30 - n);
    unique case (sel)
      TBL_COS:  res = to_q16(cos_mu30(x));
      TBL_LOG:  res = to_q16(log_fall30(x));
      TBL_GAM:  res = to_q16(mul30(mul30(x, x), root30(x, 5)));
      TBL_IGAM: res = to_q16(root30(pow30(x, 5), 11));
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/kfi_rom.sv =====
module kfi_rom #(
  parameter int ADDR_BITS = kfi_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [kfi_pkg::PHASE_W-1:0]   phase,
  input  kfi_pkg::tbl_t                 sel,
  output logic [kfi_pkg::MU_W-1:0]      mu
);

  localparam int FRAC  = 16 - ADDR_BITS;
  localparam int DEPTH = (1 << ADDR_BITS) + 1;
  localparam int IW    = ADDR_BITS + 1;
  localparam int FW    = FRAC + 1;
  localparam int SW    = kfi_pkg::MU_W + FW;
  localparam logic [IW-1:0] LAST  = IW'(DEPTH - 1);
  localparam logic [FW-1:0] F_ONE = FW'(1 << FRAC);

  logic [kfi_pkg::MU_W-1:0] cos_tab  [DEPTH];
  logic [kfi_pkg::MU_W-1:0] log_tab  [DEPTH];
  logic [kfi_pkg::MU_W-1:0] gam_tab  [DEPTH];
  logic [kfi_pkg::MU_W-1:0] igam_tab [DEPTH];

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_ent
    localparam logic [kfi_pkg::MU_W-1:0] C_COS =
      kfi_pkg::rom_entry(kfi_pkg::TBL_COS, gi, ADDR_BITS);
    localparam logic [kfi_pkg::MU_W-1:0] C_LOG =
      kfi_pkg::rom_entry(kfi_pkg::TBL_LOG, gi, ADDR_BITS);
    localparam logic [kfi_pkg::MU_W-1:0] C_GAM =
      kfi_pkg::rom_entry(kfi_pkg::TBL_GAM, gi, ADDR_BITS);
    localparam logic [kfi_pkg::MU_W-1:0] C_IGAM =
      kfi_pkg::rom_entry(kfi_pkg::TBL_IGAM, gi, ADDR_BITS);
    assign cos_tab[gi]  = C_COS;
    assign log_tab[gi]  = C_LOG;
    assign gam_tab[gi]  = C_GAM;
    assign igam_tab[gi] = C_IGAM;
  end

  logic [IW-1:0]            idx, idx1;
  logic [kfi_pkg::MU_W-1:0] rd0, rd1;
  logic [kfi_pkg::MU_W-1:0] t0, t1;
  logic [FRAC-1:0]          fr;
  logic [SW-1:0]            mix;

  assign idx  = phase[kfi_pkg::PHASE_W-1:FRAC];
  assign idx1 = (idx == LAST) ? idx : idx + IW'(1);

  always_comb begin
    unique case (sel)
      kfi_pkg::TBL_COS:  begin rd0 = cos_tab[idx];  rd1 = cos_tab[idx1];  end
      kfi_pkg::TBL_LOG:  begin rd0 = log_tab[idx];  rd1 = log_tab[idx1];  end
      kfi_pkg::TBL_GAM:  begin rd0 = gam_tab[idx];  rd1 = gam_tab[idx1];  end
      kfi_pkg::TBL_IGAM: begin rd0 = igam_tab[idx]; rd1 = igam_tab[idx1]; end
    endcase
  end

  // lookup stage
  always_ff @(posedge clk) begin
    if (adv) begin
      t0 <= rd0;
      t1 <= rd1;
      fr <= phase[FRAC-1:0];
    end
  end

  // interpolation stage
  assign mix = SW'(t0) * SW'(F_ONE - FW'(fr)) + SW'(t1) * SW'(fr);

  always_ff @(posedge clk) begin
    if (adv) begin
      mu <= kfi_pkg::MU_W'(mix >> FRAC);
    end
  end

endmodule

// ===== hw/rtl/kfi_div.sv =====
module kfi_div (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [kfi_pkg::QUO_W-1:0]   dividend,
  input  logic [kfi_pkg::TIME_W-1:0]  divisor,
  output logic [kfi_pkg::QUO_W-1:0]   quotient
);

  localparam int QW = kfi_pkg::QUO_W;
  localparam int TW = kfi_pkg::TIME_W;

  // one quotient bit per stage, dividend shifts out as quotient shifts in
  logic [QW-1:0] dq  [1:QW];
  logic [TW-1:0] rem [1:QW];
  logic [TW-1:0] dv  [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [QW-1:0] cur_dq;
    logic [TW-1:0] cur_rem, cur_dv;
    logic [TW:0]   sh, df;
    logic          take;

    if (k == 0) begin : g_first
      assign cur_dq  = dividend;
      assign cur_rem = '0;
      assign cur_dv  = divisor;
    end else begin : g_next
      assign cur_dq  = dq[k];
      assign cur_rem = rem[k];
      assign cur_dv  = dv[k];
    end

    assign sh   = {cur_rem, cur_dq[QW-1]};
    assign df   = sh - {1'b0, cur_dv};
    assign take = ~df[TW];

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= take ? df[TW-1:0] : sh[TW-1:0];
        dq[k+1]  <= {cur_dq[QW-2:0], take};
        dv[k+1]  <= cur_dv;
      end
    end
  end

  assign quotient = dq[QW];

endmodule

// ===== hw/rtl/kfi_blend.sv =====
module kfi_blend (
  input  logic                              clk,
  input  logic                              adv,
  input  logic [3:0]                        mode,
  input  logic signed [kfi_pkg::VAL_W-1:0]  v1,
  input  logic signed [kfi_pkg::VAL_W-1:0]  v2,
  input  logic [kfi_pkg::PHASE_W-1:0]       pc,
  input  logic [kfi_pkg::MU_W-1:0]          mu,
  output logic signed [kfi_pkg::VAL_W+2:0]  val
);

  localparam int AW = kfi_pkg::VAL_W + 1;
  localparam int PW = AW + kfi_pkg::MU_W;
  localparam int RW = PW - 16;

  logic signed [AW-1:0]             a_c;
  logic signed [kfi_pkg::VAL_W-1:0] base_c;
  logic [kfi_pkg::MU_W-1:0]         md_c;
  logic                             rom_c;

  logic signed [AW-1:0]             a1_a, a2_a;
  logic signed [kfi_pkg::VAL_W-1:0] a1_base, a2_base, p_base;
  logic [kfi_pkg::MU_W-1:0]         a1_md, a2_md;
  logic                             a1_rom, a2_rom;
  logic signed [PW-1:0]             prod;

  logic [kfi_pkg::MU_W-1:0]         m_sel;
  logic signed [kfi_pkg::MU_W:0]    m_s;
  logic signed [RW-1:0]             rnd;

  // operand choice per mode
  always_comb begin
    a_c    = AW'(v2) - AW'(v1);
    base_c = v1;
    md_c   = pc;
    rom_c  = 1'b0;
    unique case (kfi_pkg::mode_t'(mode))
      kfi_pkg::MODE_LINEAR: ;
      kfi_pkg::MODE_COSINE,
      kfi_pkg::MODE_GAMMA,
      kfi_pkg::MODE_INV_GAMMA: rom_c = 1'b1;
      kfi_pkg::MODE_FALL: begin
        a_c    = AW'(v1);
        base_c = '0;
        md_c   = kfi_pkg::PHASE_ONE - pc;
      end
      kfi_pkg::MODE_RISE: begin
        a_c    = AW'(v2);
        base_c = '0;
      end
      kfi_pkg::MODE_LOG_FALL: begin
        a_c    = AW'(v1);
        base_c = '0;
        rom_c  = 1'b1;
      end
      default: begin
        a_c  = '0;
        md_c = '0;
      end
    endcase
  end

  // two operand stages line up with the table lookup
  always_ff @(posedge clk) begin
    if (adv) begin
      a1_a    <= a_c;
      a1_base <= base_c;
      a1_md   <= md_c;
      a1_rom  <= rom_c;
      a2_a    <= a1_a;
      a2_base <= a1_base;
      a2_md   <= a1_md;
      a2_rom  <= a1_rom;
    end
  end

  assign m_sel = a2_rom ? mu : a2_md;
  assign m_s   = signed'({1'b0, m_sel});

  always_ff @(posedge clk) begin
    if (adv) begin
      prod   <= PW'(a2_a) * PW'(m_s);
      p_base <= a2_base;
    end
  end

  // round half up: floor(x / 65536 + 0.5)
  assign rnd = RW'((prod + PW'(32768)) >>> 16);

  always_ff @(posedge clk) begin
    if (adv) begin
      val <= (kfi_pkg::VAL_W + 3)'(p_base) + (kfi_pkg::VAL_W + 3)'(rnd);
    end
  end

endmodule

// ===== hw/rtl/keyframe_interpolator.sv =====
// keyframe interpolator, fully pipelined
// stages: input register, 48 stages of the time divider at one quotient bit
//   each, output register
// throughput: one beat per cycle; a held result stalls the whole pipeline
// reset: synchronous, clears the valid bits only, tables are constant logic
module keyframe_interpolator #(
  parameter int TABLE_ADDR_BITS = kfi_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  logic [3:0]                         mode,
  input  logic signed [kfi_pkg::VAL_W-1:0]   start_value,
  input  logic signed [kfi_pkg::VAL_W-1:0]   end_value,
  input  logic [kfi_pkg::TIME_W-1:0]         start_time,
  input  logic [kfi_pkg::TIME_W-1:0]         now_time,
  input  logic [kfi_pkg::PHASE_W-1:0]        phase,
  input  logic [kfi_pkg::TIME_W-1:0]         span,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic signed [kfi_pkg::VAL_W-1:0]   value,
  output logic                               saturated
);

  localparam int QW      = kfi_pkg::QUO_W;
  localparam int VW      = kfi_pkg::VAL_W;
  // input register + divider stages + output register
  localparam int LAT     = QW + 2;
  // blend result arrives BLEND_LAT stages after the input register
  localparam int VAL_DLY = QW - kfi_pkg::BLEND_LAT;
  localparam int WIDE_W  = QW + 3;

  typedef struct packed {
    logic [3:0]           mode;
    logic signed [VW-1:0] v1;
    logic                 dneg;
    logic                 spanz;
  } side_t;

  // global advance: everything moves unless the output beat is held
  logic adv;
  assign adv        = ~result_valid | result_ready;
  assign item_ready = adv;

  logic [LAT:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:1], item_valid};
    end
  end

  assign result_valid = vld[LAT];

  // input register: phase clamp, time difference, table select
  logic [3:0]                     s1_mode;
  logic signed [VW-1:0]           s1_v1, s1_v2;
  logic [kfi_pkg::PHASE_W-1:0]    s1_pc;
  logic                           s1_dneg, s1_spanz;
  logic [kfi_pkg::TIME_W-1:0]     s1_dmag, s1_span;
  kfi_pkg::tbl_t                  s1_sel;
  logic                           back_in_time;

  assign back_in_time = now_time < start_time;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode  <= mode;
      s1_v1    <= start_value;
      s1_v2    <= end_value;
      // anything at or past one reads as exactly one
      s1_pc    <= phase[kfi_pkg::PHASE_W-1] ? kfi_pkg::PHASE_ONE : phase;
      s1_dneg  <= back_in_time;
      s1_dmag  <= back_in_time ? start_time - now_time : now_time - start_time;
      s1_span  <= span;
      s1_spanz <= (span == '0);
      s1_sel   <= kfi_pkg::tbl_of(mode);
    end
  end

  // curve lookup with linear interpolation; the weight passes two registered stages, lookup and interpolation
  logic [kfi_pkg::MU_W-1:0] mu;

  kfi_rom #(
    .ADDR_BITS (TABLE_ADDR_BITS)
  ) u_rom (
    .clk   (clk),
    .adv   (adv),
    .phase (s1_pc),
    .sel   (s1_sel),
    .mu    (mu)
  );

  // value blend: one multiply, rounding and base add
  logic signed [VW+2:0] blend_val;

  kfi_blend u_blend (
    .clk  (clk),
    .adv  (adv),
    .mode (s1_mode),
    .v1   (s1_v1),
    .v2   (s1_v2),
    .pc   (s1_pc),
    .mu   (mu),
    .val  (blend_val)
  );

  // elapsed time over span for the forward and backward modes
  logic [QW-1:0] quo;

  kfi_div u_div (
    .clk      (clk),
    .adv      (adv),
    .dividend ({s1_dmag, 16'h0000}),
    .divisor  (s1_span),
    .quotient (quo)
  );

  // sideband and blend result ride along to meet the quotient
  side_t                side [1:QW];
  logic signed [VW+2:0] vdly [1:VAL_DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      side[1] <= '{mode: s1_mode, v1: s1_v1, dneg: s1_dneg, spanz: s1_spanz};
      for (int k = 2; k <= QW; k++) side[k] <= side[k-1];
      vdly[1] <= blend_val;
      for (int k = 2; k <= VAL_DLY; k++) vdly[k] <= vdly[k-1];
    end
  end

  // final merge and clamp
  side_t                    fin;
  logic signed [WIDE_W-1:0] q_s, wide;
  logic                     zero_span, add_q, ovf_hi, ovf_lo;
  logic [VW-1:0]            value_next;
  logic                     saturated_next;

  assign fin   = side[QW];
  assign q_s   = signed'(WIDE_W'(quo));
  // forward adds the offset, backward subtracts it; a negative time difference swaps the two
  assign add_q = (kfi_pkg::mode_t'(fin.mode) == kfi_pkg::MODE_FORWARD) ^ fin.dneg;

  always_comb begin
    zero_span = 1'b0;
    unique case (kfi_pkg::mode_t'(fin.mode))
      kfi_pkg::MODE_LINEAR,
      kfi_pkg::MODE_COSINE,
      kfi_pkg::MODE_FALL,
      kfi_pkg::MODE_RISE,
      kfi_pkg::MODE_LOG_FALL,
      kfi_pkg::MODE_GAMMA,
      kfi_pkg::MODE_INV_GAMMA: wide = WIDE_W'(vdly[VAL_DLY]);
      kfi_pkg::MODE_FORWARD,
      kfi_pkg::MODE_BACKWARD: begin
        if (fin.spanz) begin
          wide      = WIDE_W'(fin.v1);
          zero_span = 1'b1;
        end else if (add_q) begin
          wide = WIDE_W'(fin.v1) + q_s;
        end else begin
          wide = WIDE_W'(fin.v1) - q_s;
        end
      end
      // hold and unused codes keep the first key
      default: wide = WIDE_W'(fin.v1);
    endcase
  end

  assign ovf_hi = ~wide[WIDE_W-1] & (|wide[WIDE_W-2:VW-1]);
  assign ovf_lo = wide[WIDE_W-1] & ~(&wide[WIDE_W-2:VW-1]);

  always_comb begin
    priority if (ovf_hi) value_next = kfi_pkg::VAL_MAX;
    else if (ovf_lo)     value_next = kfi_pkg::VAL_MIN;
    else                 value_next = wide[VW-1:0];
  end

  assign saturated_next = ovf_hi | ovf_lo | zero_span;

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      value     <= signed'(value_next);
      saturated <= saturated_next;
    end
  end

endmodule
